// File: rtl/bmfa_pkg.sv
// Shared constants and types for the bitmap lowest free slot allocator.
`default_nettype none

package bmfa_pkg;

    localparam int DEF_MAP_WORDS = 16;
    localparam int DEF_WORD_BITS = 64;

    localparam int IDX_W = 10;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             status;
        logic [IDX_W-1:0] index;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/bmfa_map_ram.sv
// Free bitmap storage: one write port, one read port, registered read data.
`default_nettype none

module bmfa_map_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bmfa_prio_enc.sv
// Lowest set bit encoder for one bitmap word.
`default_nettype none

module bmfa_prio_enc #(
    parameter int WORD_BITS = 64,
    parameter int BW        = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] word,
    output logic                      found,
    output logic      [BW-1:0]        idx
);

    always_comb
    begin
        found = |word;
        idx   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (word[b])
            begin
                idx = BW'(b);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bmfa_ctrl.sv
// Sequencer: clearing pass, read-modify-write of map words and forward scan.
`default_nettype none

module bmfa_ctrl #(
    parameter int MAP_WORDS = bmfa_pkg::DEF_MAP_WORDS,
    parameter int WORD_BITS = bmfa_pkg::DEF_WORD_BITS,
    parameter int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       func,
    input  wire logic [bmfa_pkg::IDX_W-1:0] slot_index,
    output bmfa_pkg::res_t                  res,
    input  wire logic                       res_stall,
    output logic                            ram_we,
    output logic      [AW-1:0]              ram_waddr,
    output logic      [WORD_BITS-1:0]       ram_wdata,
    output logic                            ram_re,
    output logic      [AW-1:0]              ram_raddr,
    input  wire logic [WORD_BITS-1:0]       ram_rdata
);

    import bmfa_pkg::*;

    localparam int LFW       = $clog2(MAP_WORDS + 1);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int IW        = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int GW        = (IW > IDX_W) ? IW : IDX_W;
    localparam int QCW       = (LFW > IDX_W) ? LFW : IDX_W;
    localparam int DIV_SHIFT = IDX_W + BW;
    localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W    = IDX_W + DIV_SHIFT;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_AMOD   = 3'd2;
    localparam logic [2:0] ST_ASCAN  = 3'd3;
    localparam logic [2:0] ST_FDIV   = 3'd4;
    localparam logic [2:0] ST_FREAD  = 3'd5;
    localparam logic [2:0] ST_FWRITE = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]       state_reg,      state_next;
    logic [LFW-1:0]   addr_reg,       addr_next;
    logic [LFW-1:0]   lf_word_reg,    lf_word_next;
    logic [BW-1:0]    lf_bit_reg,     lf_bit_next;
    logic [IDX_W-1:0] slot_reg,       slot_next;
    logic [IDX_W-1:0] q_reg,          q_next;
    logic [BW-1:0]    r_reg,          r_next;
    logic [IDX_W-1:0] res_index_reg,  res_index_next;
    logic             res_status_reg, res_status_next;

    logic                 accept;
    logic                 map_full;
    logic [GW-1:0]        granted;
    logic [PROD_W-1:0]    div_prod;
    logic [IDX_W-1:0]     q_full;
    logic [IDX_W-1:0]     rem_full;
    logic [WORD_BITS-1:0] cleared;
    logic [WORD_BITS-1:0] enc_word;
    logic                 enc_found;
    logic [BW-1:0]        enc_idx;
    logic [LFW-1:0]       lf_word_inc;
    logic [LFW-1:0]       addr_inc;
    logic                 freed_lower;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign map_full    = (lf_word_reg == LFW'(MAP_WORDS));
    assign granted     = GW'(lf_word_reg) * GW'(WORD_BITS) + GW'(lf_bit_reg);
    assign div_prod    = PROD_W'(slot_reg) * PROD_W'(DIV_MULT);
    assign q_full      = div_prod[DIV_SHIFT +: IDX_W];
    assign rem_full    = slot_reg - IDX_W'(q_reg * IDX_W'(WORD_BITS));
    assign cleared     = ram_rdata & ~(WORD_BITS'(1) << lf_bit_reg);
    assign enc_word    = (state_reg == ST_AMOD) ? cleared : ram_rdata;
    assign lf_word_inc = lf_word_reg + LFW'(1);
    assign addr_inc    = addr_reg + LFW'(1);
    assign freed_lower = (QCW'(q_reg) < QCW'(lf_word_reg))
                      || ((QCW'(q_reg) == QCW'(lf_word_reg)) && (r_reg < lf_bit_reg));

    assign res.valid  = (state_reg == ST_DONE);
    assign res.status = res_status_reg;
    assign res.index  = res_index_reg;

    bmfa_prio_enc #(
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
    ) u_prio_enc (
        .word  (enc_word),
        .found (enc_found),
        .idx   (enc_idx)
    );

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        lf_word_next    = lf_word_reg;
        lf_bit_next     = lf_bit_reg;
        slot_next       = slot_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = lf_word_reg[AW-1:0];
        ram_wdata       = cleared;
        ram_re          = 1'b0;
        ram_raddr       = lf_word_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg[AW-1:0];
                ram_wdata = '1;
                addr_next = addr_inc;
                if (addr_reg == LFW'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next       = slot_index;
                    res_status_next = STATUS_DONE;
                    res_index_next  = '0;
                    if (func == FUNC_FREE)
                    begin
                        state_next = ST_FDIV;
                    end
                    else if (map_full)
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_index_next = granted[IDX_W-1:0];
                        ram_re         = 1'b1;
                        state_next     = ST_AMOD;
                    end
                end
            end
            ST_AMOD:
            begin
                ram_we = 1'b1;
                if (enc_found)
                begin
                    lf_bit_next = enc_idx;
                    state_next  = ST_DONE;
                end
                else if (lf_word_reg == LFW'(MAP_WORDS - 1))
                begin
                    lf_word_next = LFW'(MAP_WORDS);
                    lf_bit_next  = '0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lf_word_inc[AW-1:0];
                    addr_next  = lf_word_inc;
                    state_next = ST_ASCAN;
                end
            end
            ST_ASCAN:
            begin
                if (enc_found)
                begin
                    lf_word_next = addr_reg;
                    lf_bit_next  = enc_idx;
                    state_next   = ST_DONE;
                end
                else if (addr_reg == LFW'(MAP_WORDS - 1))
                begin
                    lf_word_next = LFW'(MAP_WORDS);
                    lf_bit_next  = '0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_inc[AW-1:0];
                    addr_next = addr_inc;
                end
            end
            ST_FDIV:
            begin
                q_next = q_full;
                if (QCW'(q_full) < QCW'(MAP_WORDS))
                begin
                    state_next = ST_FREAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = q_reg[AW-1:0];
                r_next     = rem_full[BW-1:0];
                state_next = ST_FWRITE;
            end
            ST_FWRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = q_reg[AW-1:0];
                ram_wdata = ram_rdata | (WORD_BITS'(1) << r_reg);
                if (freed_lower)
                begin
                    lf_word_next = LFW'(q_reg);
                    lf_bit_next  = r_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            lf_word_reg <= '0;
            lf_bit_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            lf_word_reg <= lf_word_next;
            lf_bit_reg  <= lf_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        q_reg          <= q_next;
        r_reg          <= r_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
    end

endmodule

`default_nettype wire

// File: rtl/bitmap_lowest_free_slot_allocator.sv
// Allocate: the lowest free bit's word is read and written back with that bit cleared,
// then later words are scanned as needed; refused allocate skips the map; free sets its bit.
// Next beat is taken the cycle after the result leaves the sequencer; one item at a time,
// bounded by the single map memory and the word-per-cycle forward scan.
// Reset: a clearing pass writes every map word to all free, in_stall high meanwhile;
// the lowest free index resets to zero.
`default_nettype none

module bitmap_lowest_free_slot_allocator #(
    parameter int MAP_WORDS = bmfa_pkg::DEF_MAP_WORDS,
    parameter int WORD_BITS = bmfa_pkg::DEF_WORD_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       func,
    input  wire logic [bmfa_pkg::IDX_W-1:0] slot_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [bmfa_pkg::IDX_W-1:0] granted_index,
    output logic                            status
);

    import bmfa_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    res_t                 res;
    logic                 res_stall;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] granted_reg;
    logic             status_reg;

    bmfa_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmfa_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .slot_index (slot_index),
        .res        (res),
        .res_stall  (res_stall),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    assign res_stall = out_valid_reg && out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!res_stall)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && !res_stall)
        begin
            granted_reg <= res.index;
            status_reg  <= res.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire
